// File: rtl/crow_pkg.sv
// Package for the chunk ray occlusion walk: sizes, codes, command and status types.
// No dependencies; the top level, controller, datapath and divider import it.
`timescale 1ns / 1ps
`default_nettype none
package crow_pkg;

	localparam int CHUNK_SIZE = 16;
	localparam int MAP_SIDE   = 32;
	localparam int FRAC_BITS  = 8;

	localparam int COORD_W     = $clog2(MAP_SIDE);
	localparam int ROW_AW      = 2 * COORD_W;
	localparam int MAP_HALF    = MAP_SIDE / 2;
	localparam int CHUNK_SHIFT = $clog2(CHUNK_SIZE) + FRAC_BITS;
	localparam int Q_SHIFT     = 16 - FRAC_BITS;
	localparam int STEP_SHIFT  = 16 + $clog2(CHUNK_SIZE);

	localparam int DIV_NW = 40;
	localparam int DIV_DW = 20;

	localparam logic [31:0] Q_MAX    = 32'hFFFF_FFFF;
	localparam logic [6:0]  STEP_MAX = 7'd127;
	localparam logic [15:0] NEAR_MIN = 16'd3;

	localparam logic [1:0] REG_CAM_X = 2'd0;
	localparam logic [1:0] REG_CAM_Y = 2'd1;
	localparam logic [1:0] REG_CAM_Z = 2'd2;
	localparam logic [1:0] REG_NEAR  = 2'd3;

	localparam logic [1:0] OUT_REACHED    = 2'd0;
	localparam logic [1:0] OUT_HIT        = 2'd1;
	localparam logic [1:0] OUT_EXHAUSTED  = 2'd2;
	localparam logic [1:0] OUT_DEGENERATE = 2'd3;

	localparam logic [4:0] OP_NONE      = 5'd0;
	localparam logic [4:0] OP_CLR       = 5'd1;
	localparam logic [4:0] OP_LOAD      = 5'd2;
	localparam logic [4:0] OP_WRRD      = 5'd3;
	localparam logic [4:0] OP_WRWR      = 5'd4;
	localparam logic [4:0] OP_RAY       = 5'd5;
	localparam logic [4:0] OP_SQ        = 5'd6;
	localparam logic [4:0] OP_SQRT_INIT = 5'd7;
	localparam logic [4:0] OP_SQRT_STEP = 5'd8;
	localparam logic [4:0] OP_OFFMUL    = 5'd9;
	localparam logic [4:0] OP_DIV_OFF   = 5'd10;
	localparam logic [4:0] OP_START     = 5'd11;
	localparam logic [4:0] OP_GMUL      = 5'd12;
	localparam logic [4:0] OP_DIV_NC    = 5'd13;
	localparam logic [4:0] OP_NC        = 5'd14;
	localparam logic [4:0] OP_DIV_CS    = 5'd15;
	localparam logic [4:0] OP_CS        = 5'd16;
	localparam logic [4:0] OP_INF       = 5'd17;
	localparam logic [4:0] OP_SPAN      = 5'd18;
	localparam logic [4:0] OP_MRD       = 5'd19;
	localparam logic [4:0] OP_WSTEP     = 5'd20;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] axis;
	} crow_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_busy;
		logic sq_zero;
		logic ray_zero;
		logic steps_zero;
		logic at_target;
		logic solid_here;
	} crow_status_t;

endpackage
`default_nettype wire

// File: rtl/crow_item_if.sv
// Input item channel: valid/ready handshake with command and chunk payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface crow_item_if;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic signed [4:0] chunk_x;
	logic signed [4:0] chunk_y;
	logic signed [4:0] chunk_z;
	logic              solid;
	modport source(output valid, cmd, chunk_x, chunk_y, chunk_z, solid, input ready);
	modport sink(input valid, cmd, chunk_x, chunk_y, chunk_z, solid, output ready);
endinterface
`default_nettype wire

// File: rtl/crow_result_if.sv
// Result channel: valid/ready handshake with occlusion flag and outcome code.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface crow_result_if;
	logic       valid;
	logic       ready;
	logic       occluded;
	logic [1:0] outcome;
	modport source(output valid, occluded, outcome, input ready);
	modport sink(input valid, occluded, outcome, output ready);
endinterface
`default_nettype wire

// File: rtl/crow_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface crow_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [16:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/chunk_ray_occlusion_walk.sv
// Top level of the chunk ray occlusion walk: channel interfaces, controller and
// datapath. Depends on crow_pkg, the crow_*_if interfaces, crow_ctrl and crow_dp.
//
// After reset the block clears its 1024-row occupancy memory, one row per cycle,
// and takes no item until the clear is done (configuration writes are taken at any
// time). A write item reads its row and writes it back. A query sums the squared
// ray components and runs the bit-serial square root, then per axis three divisions
// from the shared bit-serial divider (only the offset division for an axis the ray
// does not move along), then the walk, which reads and checks a row per step and is
// bounded by the largest axis distance plus two, capped at STEP_MAX. A camera at
// the target centre gets the degenerate outcome. One item is in work at a time;
// a finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none
module chunk_ray_occlusion_walk
	import crow_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	crow_cfg_if.sink      cfg,
	crow_item_if.sink     item,
	crow_result_if.source result
);

	crow_cmd_t    cmd;
	crow_status_t status;
	logic [1:0]   outcome;

	assign cfg.ready = 1'b1;

	crow_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_cmd    (item.cmd),
		.item_ready  (item.ready),
		.res_valid   (result.valid),
		.res_outcome (outcome),
		.res_ready   (result.ready),
		.status      (status),
		.cmd         (cmd)
	);

	crow_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_x     (item.chunk_x),
		.in_y     (item.chunk_y),
		.in_z     (item.chunk_z),
		.in_solid (item.solid),
		.cfg_we   (cfg.valid),
		.cfg_idx  (cfg.index),
		.cfg_data (cfg.data),
		.status   (status)
	);

	assign result.outcome  = outcome;
	assign result.occluded = outcome == OUT_HIT;

endmodule
`default_nettype wire

// File: rtl/crow_div.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on crow_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none
module crow_div
	import crow_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_NW-1:0] dividend,
	input  wire logic [DIV_DW-1:0] divisor,
	output logic                   busy,
	output logic [DIV_NW-1:0]      quotient,
	output logic                   rem_nz
);

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_DW:0]   rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_DW:0]   rem_sh;
	logic              fits;

	assign rem_sh = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;
	assign rem_nz   = rem_q != '0;

endmodule
`default_nettype wire

// File: rtl/crow_dp.sv
// Datapath: configuration registers, occupancy row memory, ray setup arithmetic,
// square root iteration and DDA walk registers. Uses crow_pkg and crow_div.
`timescale 1ns / 1ps
`default_nettype none
module crow_dp
	import crow_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire crow_cmd_t         cmd,
	input  wire logic signed [4:0] in_x,
	input  wire logic signed [4:0] in_y,
	input  wire logic signed [4:0] in_z,
	input  wire logic              in_solid,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_idx,
	input  wire logic [16:0]       cfg_data,
	output crow_status_t           status
);

	function automatic logic [8:0] win_off(input logic [7:0] c);
		win_off = 9'({c[7], c}) + 9'(MAP_HALF);
	endfunction

	function automatic logic in_win(input logic [8:0] o);
		in_win = !o[8] && (o[7:0] < 8'(MAP_SIDE));
	endfunction

	logic signed [4:0]  tgt_q [3];
	logic               solid_q;
	logic signed [16:0] cam_q [3];
	logic [15:0]        near_q;
	logic signed [17:0] ray_q [3];
	logic [35:0]        sq_q;
	logic [35:0]        sqsrc_q;
	logic [20:0]        srem_q;
	logic [17:0]        len_q;
	logic [DIV_NW-1:0]  prod_q;
	logic               offneg_q;
	logic signed [7:0]  wc_q [3];
	logic [12:0]        g_q;
	logic [31:0]        nc_q [3];
	logic [31:0]        cs_q [3];
	logic [6:0]         steps_q;
	logic [ROW_AW:0]    clr_q;
	logic [MAP_SIDE-1:0] rd_q;
	logic [COORD_W-1:0] zsel_q;
	logic               rdwin_q;

	logic [MAP_SIDE-1:0] map_mem [MAP_SIDE * MAP_SIDE];

	// Per-axis operands
	logic signed [17:0] ray_a;
	logic signed [17:0] ray_neg;
	logic [16:0]        mag_a;
	logic [15:0]        near_eff;
	logic signed [18:0] ray2;
	logic signed [16:0] nears;
	logic signed [35:0] offp;
	logic [35:0]        offn;
	logic [35:0]        offabs;
	logic [33:0]        msq;
	logic [20:0]        rem_n;
	logic [20:0]        trial;
	logic               sq_fit;
	logic [19:0]        qlow;
	logic signed [19:0] off_s;
	logic signed [20:0] start_a;
	logic [CHUNK_SHIFT-1:0] frac_a;
	logic [30:0]        gl;

	// Divider interface
	logic              div_start;
	logic [DIV_NW-1:0] div_nd;
	logic [DIV_DW-1:0] div_dv;
	logic              div_busy;
	logic [DIV_NW-1:0] div_q;
	logic              div_rnz;
	logic [31:0]       div_sat;

	// Walk
	logic [1:0]         step_ax;
	logic [32:0]        nc_sum;
	logic [7:0]         dmax;
	logic [8:0]         span;
	logic [8:0]         d_abs [3];
	logic [8:0]         tw_off [3];
	logic [8:0]         ww_off [3];
	logic               t_win;
	logic               w_win;

	// Memory ports
	logic               mem_we;
	logic [ROW_AW-1:0]  mem_wa;
	logic [MAP_SIDE-1:0] mem_wd;
	logic               mem_re;
	logic [ROW_AW-1:0]  mem_ra;

	crow_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_nd),
		.divisor  (div_dv),
		.busy     (div_busy),
		.quotient (div_q),
		.rem_nz   (div_rnz)
	);

	always_comb begin
		ray_a    = ray_q[cmd.axis];
		ray_neg  = -ray_a;
		mag_a    = ray_a[17] ? ray_neg[16:0] : ray_a[16:0];
		near_eff = (near_q < NEAR_MIN) ? NEAR_MIN : near_q;
		ray2     = {ray_a, 1'b0};
		nears    = signed'({1'b0, near_eff});
		offp     = 36'(ray2) * 36'(nears);
		offn     = offp + {18'd0, len_q};
		offabs   = offn[35] ? -offn : offn;
		msq      = mag_a * mag_a;
		rem_n    = {srem_q[18:0], sqsrc_q[35:34]};
		trial    = {1'b0, len_q, 2'b01};
		sq_fit   = rem_n >= trial;
		qlow     = div_q[19:0];
		off_s    = offneg_q ? -signed'(qlow + 20'(div_rnz)) : signed'(qlow);
		start_a  = 21'(cam_q[cmd.axis]) + 21'(off_s);
		frac_a   = start_a[CHUNK_SHIFT-1:0];
		gl       = g_q * len_q;
		div_sat  = (div_q[DIV_NW-1:32] != '0) ? Q_MAX : div_q[31:0];
	end

	always_comb begin
		div_start = 1'b0;
		div_nd    = {4'd0, offabs};
		div_dv    = {1'b0, len_q, 1'b0};
		unique case (cmd.op)
			OP_DIV_OFF: begin
				div_start = 1'b1;
				div_nd    = prod_q;
			end
			OP_DIV_NC: begin
				div_start = 1'b1;
				div_nd    = prod_q;
				div_dv    = {3'd0, mag_a};
			end
			OP_DIV_CS: begin
				div_start = 1'b1;
				div_nd    = DIV_NW'({len_q, {STEP_SHIFT{1'b0}}});
				div_dv    = {3'd0, mag_a};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			tw_off[a] = win_off(8'({tgt_q[a][4], tgt_q[a][4], tgt_q[a][4], tgt_q[a]}));
			ww_off[a] = win_off(wc_q[a]);
			d_abs[a]  = 9'({tgt_q[a][4], tgt_q[a][4], tgt_q[a][4], tgt_q[a][4], tgt_q[a]})
				- 9'({wc_q[a][7], wc_q[a]});
			if (d_abs[a][8]) begin
				d_abs[a] = -d_abs[a];
			end
		end
		t_win = in_win(tw_off[0]) && in_win(tw_off[1]) && in_win(tw_off[2]);
		w_win = in_win(ww_off[0]) && in_win(ww_off[1]) && in_win(ww_off[2]);
		dmax  = d_abs[0][7:0];
		if (d_abs[1][7:0] > dmax) begin
			dmax = d_abs[1][7:0];
		end
		if (d_abs[2][7:0] > dmax) begin
			dmax = d_abs[2][7:0];
		end
		span = {1'b0, dmax} + 9'd2;
	end

	// Tie rule: x only when strictly smallest, y when strictly below z, else z
	always_comb begin
		if (nc_q[0] < nc_q[1]) begin
			step_ax = (nc_q[0] < nc_q[2]) ? 2'd0 : 2'd2;
		end else begin
			step_ax = (nc_q[1] < nc_q[2]) ? 2'd1 : 2'd2;
		end
		nc_sum = {1'b0, nc_q[step_ax]} + {1'b0, cs_q[step_ax]};
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = {tw_off[0][COORD_W-1:0], tw_off[1][COORD_W-1:0]};
		mem_wd = rd_q;
		mem_wd[tw_off[2][COORD_W-1:0]] = solid_q;
		mem_re = 1'b0;
		mem_ra = {tw_off[0][COORD_W-1:0], tw_off[1][COORD_W-1:0]};
		unique case (cmd.op)
			OP_CLR: begin
				mem_we = 1'b1;
				mem_wa = clr_q[ROW_AW-1:0];
				mem_wd = '0;
			end
			OP_WRRD: begin
				mem_re = 1'b1;
			end
			OP_WRWR: begin
				mem_we = t_win;
			end
			OP_MRD: begin
				mem_re = 1'b1;
				mem_ra = {ww_off[0][COORD_W-1:0], ww_off[1][COORD_W-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= map_mem[mem_ra];
		end
	end

	// Control and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0] <= '0;
			cam_q[1] <= '0;
			cam_q[2] <= '0;
			near_q   <= 16'd26;
			clr_q    <= '0;
			steps_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_CAM_X: cam_q[0] <= signed'(cfg_data);
					REG_CAM_Y: cam_q[1] <= signed'(cfg_data);
					REG_CAM_Z: cam_q[2] <= signed'(cfg_data);
					REG_NEAR:  near_q   <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
			unique case (cmd.op)
				OP_CLR:   clr_q   <= clr_q + 1'b1;
				OP_SPAN:  steps_q <= (span > {2'b0, STEP_MAX}) ? STEP_MAX : span[6:0];
				OP_WSTEP: steps_q <= steps_q - 1'b1;
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				tgt_q[0] <= in_x;
				tgt_q[1] <= in_y;
				tgt_q[2] <= in_z;
				solid_q  <= in_solid;
			end
			OP_RAY: begin
				for (int a = 0; a < 3; a++) begin
					ray_q[a] <= 18'(signed'({tgt_q[a], 1'b1, {(CHUNK_SHIFT-1){1'b0}}}))
						- 18'(cam_q[a]);
				end
				sq_q <= '0;
			end
			OP_SQ: begin
				sq_q <= sq_q + {2'd0, msq};
			end
			OP_SQRT_INIT: begin
				sqsrc_q <= sq_q;
				srem_q  <= '0;
				len_q   <= '0;
			end
			OP_SQRT_STEP: begin
				sqsrc_q <= {sqsrc_q[33:0], 2'b00};
				srem_q  <= sq_fit ? rem_n - trial : rem_n;
				len_q   <= {len_q[16:0], sq_fit};
			end
			OP_OFFMUL: begin
				prod_q   <= {4'd0, offabs};
				offneg_q <= offn[35];
			end
			OP_START: begin
				wc_q[cmd.axis] <= start_a[CHUNK_SHIFT+7:CHUNK_SHIFT];
				g_q <= (!ray_a[17]) ? 13'(1 << CHUNK_SHIFT) - 13'(frac_a) : 13'(frac_a);
			end
			OP_GMUL: begin
				prod_q <= DIV_NW'({gl, {Q_SHIFT{1'b0}}});
			end
			OP_NC: begin
				nc_q[cmd.axis] <= div_sat;
			end
			OP_CS: begin
				cs_q[cmd.axis] <= div_sat;
			end
			OP_INF: begin
				nc_q[cmd.axis] <= Q_MAX;
				cs_q[cmd.axis] <= Q_MAX;
			end
			OP_MRD: begin
				zsel_q  <= ww_off[2][COORD_W-1:0];
				rdwin_q <= w_win;
			end
			OP_WSTEP: begin
				if (ray_q[step_ax] != '0) begin
					wc_q[step_ax] <= ray_q[step_ax][17] ? wc_q[step_ax] - 8'sd1
						: wc_q[step_ax] + 8'sd1;
				end
				nc_q[step_ax] <= nc_sum[32] ? Q_MAX : nc_sum[31:0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		status.clr_done   = clr_q[ROW_AW];
		status.div_busy   = div_busy;
		status.sq_zero    = sq_q == '0;
		status.ray_zero   = ray_a == '0;
		status.steps_zero = steps_q == '0;
		status.at_target  = (wc_q[0] == 8'(tgt_q[0])) && (wc_q[1] == 8'(tgt_q[1]))
			&& (wc_q[2] == 8'(tgt_q[2]));
		status.solid_here = rdwin_q && rd_q[zsel_q];
	end

endmodule
`default_nettype wire

// File: rtl/crow_ctrl.sv
// Controller: sequences clearing, map writes, ray setup and the DDA walk, and
// holds the result register. Uses crow_pkg command and status types.
`timescale 1ns / 1ps
`default_nettype none
module crow_ctrl
	import crow_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	input  wire logic         item_cmd,
	output logic              item_ready,
	output logic              res_valid,
	output logic [1:0]        res_outcome,
	input  wire logic         res_ready,
	input  wire crow_status_t status,
	output crow_cmd_t         cmd
);

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_WRD   = 5'd2;
	localparam logic [4:0] S_WWR   = 5'd3;
	localparam logic [4:0] S_RAY   = 5'd4;
	localparam logic [4:0] S_SQ    = 5'd5;
	localparam logic [4:0] S_ZCHK  = 5'd6;
	localparam logic [4:0] S_SQRT  = 5'd7;
	localparam logic [4:0] S_OFFM  = 5'd8;
	localparam logic [4:0] S_OFFDS = 5'd9;
	localparam logic [4:0] S_OFFDW = 5'd10;
	localparam logic [4:0] S_GM    = 5'd11;
	localparam logic [4:0] S_NCS   = 5'd12;
	localparam logic [4:0] S_NCW   = 5'd13;
	localparam logic [4:0] S_CSS   = 5'd14;
	localparam logic [4:0] S_CSW   = 5'd15;
	localparam logic [4:0] S_INF   = 5'd16;
	localparam logic [4:0] S_SPAN  = 5'd17;
	localparam logic [4:0] S_MRD   = 5'd18;
	localparam logic [4:0] S_MCHK  = 5'd19;
	localparam logic [4:0] S_DONE  = 5'd20;

	localparam logic [4:0] SQRT_LAST = 5'd17;

	logic [4:0] state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] pend_q, pend_d;
	logic       out_valid_q;
	logic [1:0] out_code_q;
	logic       out_load;

	assign item_ready = state_q == S_IDLE;
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || res_ready);

	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		cnt_d    = cnt_q;
		pend_d   = pend_q;
		cmd.op   = OP_NONE;
		cmd.axis = axis_q;
		unique case (state_q)
			S_CLR: begin
				if (status.clr_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.op = OP_CLR;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					cmd.op  = OP_LOAD;
					state_d = item_cmd ? S_RAY : S_WRD;
				end
			end
			S_WRD: begin
				cmd.op  = OP_WRRD;
				state_d = S_WWR;
			end
			S_WWR: begin
				cmd.op  = OP_WRWR;
				state_d = S_IDLE;
			end
			S_RAY: begin
				cmd.op  = OP_RAY;
				axis_d  = 2'd0;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op = OP_SQ;
				if (axis_q == 2'd2) begin
					state_d = S_ZCHK;
				end else begin
					axis_d = axis_q + 1'b1;
				end
			end
			S_ZCHK: begin
				if (status.sq_zero) begin
					pend_d  = OUT_DEGENERATE;
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_SQRT_INIT;
					cnt_d   = '0;
					state_d = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == SQRT_LAST) begin
					axis_d  = 2'd0;
					state_d = S_OFFM;
				end
			end
			S_OFFM: begin
				cmd.op  = OP_OFFMUL;
				state_d = S_OFFDS;
			end
			S_OFFDS: begin
				cmd.op  = OP_DIV_OFF;
				state_d = S_OFFDW;
			end
			S_OFFDW: begin
				if (!status.div_busy) begin
					cmd.op  = OP_START;
					state_d = status.ray_zero ? S_INF : S_GM;
				end
			end
			S_GM: begin
				cmd.op  = OP_GMUL;
				state_d = S_NCS;
			end
			S_NCS: begin
				cmd.op  = OP_DIV_NC;
				state_d = S_NCW;
			end
			S_NCW: begin
				if (!status.div_busy) begin
					cmd.op  = OP_NC;
					state_d = S_CSS;
				end
			end
			S_CSS: begin
				cmd.op  = OP_DIV_CS;
				state_d = S_CSW;
			end
			S_CSW: begin
				if (!status.div_busy) begin
					cmd.op = OP_CS;
					if (axis_q == 2'd2) begin
						state_d = S_SPAN;
					end else begin
						axis_d  = axis_q + 1'b1;
						state_d = S_OFFM;
					end
				end
			end
			S_INF: begin
				cmd.op = OP_INF;
				if (axis_q == 2'd2) begin
					state_d = S_SPAN;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = S_OFFM;
				end
			end
			S_SPAN: begin
				cmd.op  = OP_SPAN;
				state_d = S_MRD;
			end
			S_MRD: begin
				if (status.steps_zero) begin
					pend_d  = OUT_EXHAUSTED;
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_MRD;
					state_d = S_MCHK;
				end
			end
			S_MCHK: begin
				priority if (status.at_target) begin
					pend_d  = OUT_REACHED;
					state_d = S_DONE;
				end else if (status.solid_here) begin
					pend_d  = OUT_HIT;
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_WSTEP;
					state_d = S_MRD;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			axis_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (out_load) begin
			out_code_q <= pend_q;
		end
	end

	assign res_valid   = out_valid_q;
	assign res_outcome = out_code_q;

endmodule
`default_nettype wire

// File: dv/chunk_ray_occlusion_walk_tb.sv
// Self-checking testbench for chunk_ray_occlusion_walk: occupancy writes and ray occlusion queries.
// Depends on crow_pkg, the crow_cfg_if, crow_item_if and crow_result_if interfaces, and the block.
// A scoreboard class mirrors the occupancy map and the DDA walk in order to predict each verdict.
`timescale 1ns / 1ps
module chunk_ray_occlusion_walk_tb;
	import crow_pkg::*;

	localparam longint UNIT  = longint'(CHUNK_SIZE) << FRAC_BITS;
	localparam longint LIMIT = 4_000_000;

	typedef struct {
		logic       occluded;
		logic [1:0] outcome;
	} verdict_t;

	class occlusion_scoreboard;
		bit                 solid_map [MAP_SIDE*MAP_SIDE*MAP_SIDE];
		logic signed [16:0] cam [3];
		logic [15:0]        near_clip;
		verdict_t           pending_verdicts [$];
		int                 mismatches, results, writes, queries;
		int                 outcome_seen [4];

		function new();
			foreach (solid_map[i]) solid_map[i] = 0;
			foreach (cam[i]) cam[i] = '0;
			near_clip = 16'd26;
		endfunction

		function void set_reg(logic [1:0] idx, logic [16:0] val);
			case (idx)
				REG_CAM_X: cam[0] = val;
				REG_CAM_Y: cam[1] = val;
				REG_CAM_Z: cam[2] = val;
				REG_NEAR:  near_clip = val[15:0];
			endcase
		endfunction

		static function longint floor_div(longint a, longint b);
			longint q;
			q = a / b;
			if ((a % b) != 0 && a < 0) q--;
			return q;
		endfunction

		static function longint int_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return longint'(r);
		endfunction

		static function logic [31:0] sat_q(longint unsigned v);
			return (v > 64'hFFFF_FFFF) ? Q_MAX : v[31:0];
		endfunction

		function bit is_solid(longint c [3]);
			longint h [3];
			foreach (h[a]) begin
				h[a] = c[a] + MAP_HALF;
				if (h[a] < 0 || h[a] >= MAP_SIDE) return 0;
			end
			return solid_map[(h[0]*MAP_SIDE + h[1])*MAP_SIDE + h[2]];
		endfunction

		function verdict_t predict_walk(longint tgt [3]);
			verdict_t    v;
			longint      ray [3], walk [3], start [3], span, len, nr, off, bnd, mag, gap, d;
			int          dir [3], ax, steps;
			logic [31:0] nc [3], cs [3];
			longint unsigned sq;
			sq = 0;
			foreach (ray[a]) begin
				ray[a] = (2*tgt[a] + 1) * CHUNK_SIZE * (longint'(1) << (FRAC_BITS-1))
					- longint'(cam[a]);
				sq += longint'(ray[a] * ray[a]);
			end
			if (sq == 0) begin
				v.occluded = 0;
				v.outcome = OUT_DEGENERATE;
				return v;
			end
			len = int_sqrt(sq);
			nr = (near_clip < NEAR_MIN) ? longint'(NEAR_MIN) : longint'(near_clip);
			span = 0;
			foreach (ray[a]) begin
				off = floor_div(2*ray[a]*nr + len, 2*len);
				start[a] = longint'(cam[a]) + off;
				walk[a] = floor_div(start[a], UNIT);
				dir[a] = ray[a] > 0 ? 1 : (ray[a] < 0 ? -1 : 0);
				if (dir[a] == 0) begin
					nc[a] = Q_MAX;
					cs[a] = Q_MAX;
				end else begin
					mag = ray[a] < 0 ? -ray[a] : ray[a];
					bnd = (walk[a] + (dir[a] > 0 ? 1 : 0)) * UNIT;
					gap = bnd - start[a];
					if (gap < 0) gap = -gap;
					nc[a] = sat_q(longint'(gap * len * (longint'(1) << Q_SHIFT)) / mag);
					cs[a] = sat_q((longint'(CHUNK_SIZE) << 16) * len / mag);
				end
				d = tgt[a] - walk[a];
				if (d < 0) d = -d;
				if (d > span) span = d;
			end
			span += 2;
			steps = (span > STEP_MAX) ? int'(STEP_MAX) : int'(span);
			while (steps > 0) begin
				if (walk[0] == tgt[0] && walk[1] == tgt[1] && walk[2] == tgt[2]) begin
					v.occluded = 0;
					v.outcome = OUT_REACHED;
					return v;
				end
				if (is_solid(walk)) begin
					v.occluded = 1;
					v.outcome = OUT_HIT;
					return v;
				end
				// x only when strictly smallest, then y when strictly below z
				if (nc[0] < nc[1]) ax = (nc[0] < nc[2]) ? 0 : 2;
				else ax = (nc[1] < nc[2]) ? 1 : 2;
				walk[ax] += dir[ax];
				nc[ax] = sat_q(longint'(nc[ax]) + longint'(cs[ax]));
				steps--;
			end
			v.occluded = 0;
			v.outcome = OUT_EXHAUSTED;
			return v;
		endfunction

		function void note_item(logic op, logic signed [4:0] x, logic signed [4:0] y,
				logic signed [4:0] z, logic s);
			longint tgt [3];
			tgt[0] = x; tgt[1] = y; tgt[2] = z;
			if (op == 1'b0) begin
				writes++;
				solid_map[((tgt[0]+MAP_HALF)*MAP_SIDE + tgt[1]+MAP_HALF)*MAP_SIDE
					+ tgt[2]+MAP_HALF] = s;
			end else begin
				queries++;
				pending_verdicts.push_back(predict_walk(tgt));
			end
		endfunction

		function void check_result(logic occ, logic [1:0] outc);
			verdict_t e;
			results++;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result occluded=%0d outcome=%0d", occ, outc);
				return;
			end
			e = pending_verdicts.pop_front();
			outcome_seen[e.outcome]++;
			if (occ !== e.occluded || outc !== e.outcome) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d expected occluded=%0d outcome=%0d, got %0d/%0d",
						results, e.occluded, e.outcome, occ, outc);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   hold_req;
	bit   no_gaps;
	occlusion_scoreboard sb;

	crow_cfg_if    cfg_ch ();
	crow_item_if   item_ch ();
	crow_result_if result_ch ();

	chunk_ray_occlusion_walk dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		result_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				result_ch.ready <= 1'b0;
				hold_req--;
			end else if (stall > 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else begin
				result_ch.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.occluded, result_ch.outcome);
		end
	end

	initial begin
		longint cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("chunk_ray_occlusion_walk verification failed");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, val);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// hold item valid across back-to-back transactions; lower it only for a gap
	task automatic send_item(logic op, int x, int y, int z, logic s);
		int g;
		g = pick_gap();
		if (g > 0) begin
			item_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		item_ch.cmd     <= op;
		item_ch.chunk_x <= x[4:0];
		item_ch.chunk_y <= y[4:0];
		item_ch.chunk_z <= z[4:0];
		item_ch.solid   <= s;
		item_ch.valid   <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(op, x[4:0], y[4:0], z[4:0], s);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.pending_verdicts.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_camera(int x, int y, int z, int n);
		write_reg(REG_CAM_X, x[16:0]);
		write_reg(REG_CAM_Y, y[16:0]);
		write_reg(REG_CAM_Z, z[16:0]);
		write_reg(REG_NEAR, n[16:0]);
	endtask

	function automatic int near_coord(int r);
		return $urandom_range(0, 2*r) - r;
	endfunction

	// mostly writes and queries near the origin, some over the full window
	task automatic random_batch(int n, int r, bit mid_hold);
		int k;
		for (k = 0; k < n; k++) begin
			if (mid_hold && k == n/3) hold_req = 3000;
			if (mid_hold && k == 2*n/3) drain();
			if ($urandom_range(0, 9) < 2)
				send_item($urandom_range(0, 1), $urandom_range(0, 31) - 16,
					$urandom_range(0, 31) - 16, $urandom_range(0, 31) - 16,
					$urandom_range(0, 1));
			else if ($urandom_range(0, 9) < 5)
				send_item(1'b0, near_coord(r), near_coord(r), near_coord(r),
					$urandom_range(0, 3) == 0);
			else
				send_item(1'b1, near_coord(r), near_coord(r), near_coord(r), 1'b0);
		end
		drain();
	endtask

	initial begin
		sb = new();
		hold_req = 0;
		no_gaps = 0;
		arst_n = 0;
		item_ch.valid = 0;
		item_ch.cmd = 0;
		item_ch.chunk_x = '0;
		item_ch.chunk_y = '0;
		item_ch.chunk_z = '0;
		item_ch.solid = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = REG_CAM_X;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset camera: extremes, hit, reach, solid target, clear
		send_item(1'b0, -16, -16, -16, 1'b1);
		send_item(1'b0, 15, 15, 15, 1'b1);
		send_item(1'b1, -16, -16, -16, 1'b0);
		send_item(1'b1, 15, 15, 15, 1'b0);
		send_item(1'b0, 1, 0, 0, 1'b1);
		send_item(1'b1, 3, 0, 0, 1'b0);
		send_item(1'b1, 1, 0, 0, 1'b0);
		send_item(1'b1, 0, 0, 0, 1'b0);
		send_item(1'b0, 1, 0, 0, 1'b0);
		send_item(1'b1, 3, 0, 0, 1'b0);
		send_item(1'b1, -16, 15, -16, 1'b0);
		drain();

		// camera on a chunk centre: degenerate ray and axes with no motion
		set_camera(2048, 2048, 2048, 0);
		send_item(1'b1, 0, 0, 0, 1'b0);
		send_item(1'b0, 2, 0, 0, 1'b1);
		send_item(1'b1, 4, 0, 0, 1'b0);
		send_item(1'b1, 0, -5, 0, 1'b0);
		send_item(1'b1, 0, 0, 7, 1'b0);
		send_item(1'b1, 3, 3, 0, 1'b0);
		drain();

		// far corners of the camera range: long rays that run out of steps
		set_camera(-65536, 65535, -65536, 65535);
		send_item(1'b1, 15, -16, 15, 1'b0);
		send_item(1'b1, 0, 0, 0, 1'b0);
		drain();
		set_camera(65535, -65536, 65535, 1);
		send_item(1'b1, -16, 15, -16, 1'b0);
		send_item(1'b1, 5, 5, 5, 1'b0);
		drain();

		set_camera(300, -700, 1100, 26);
		random_batch(300, 5, 1'b1);
		no_gaps = 1;
		set_camera($urandom_range(0, 16000) - 8000, $urandom_range(0, 16000) - 8000,
			$urandom_range(0, 16000) - 8000, $urandom_range(0, 600));
		random_batch(250, 6, 1'b0);
		no_gaps = 0;
		set_camera($urandom_range(0, 131071), $urandom_range(0, 131071),
			$urandom_range(0, 131071), $urandom_range(0, 65535));
		random_batch(150, 16, 1'b0);
		set_camera(2048, -2048, 6144, 2);
		random_batch(300, 4, 1'b0);
		set_camera($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
			$urandom_range(0, 4000) - 2000, $urandom_range(0, 3000));
		random_batch(330, 7, 1'b0);

		$display("Covered %0d map writes and %0d queries, %0d results checked.",
			sb.writes, sb.queries, sb.results);
		$display("Outcomes reached/hit/exhausted/degenerate: %0d/%0d/%0d/%0d, mismatches %0d.",
			sb.outcome_seen[0], sb.outcome_seen[1], sb.outcome_seen[2],
			sb.outcome_seen[3], sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
			$display("chunk_ray_occlusion_walk verification clean");
		else
			$display("chunk_ray_occlusion_walk verification failed");
		$finish;
	end
endmodule
